// ----- hdl/vbe_pkg.sv -----
// Shared constants, codes and controller/datapath types of the VP8 boolean encoder.
package vbe_pkg;

	localparam int MAX_LITERAL_BITS = 16;
	localparam int MAX_FF_RUN       = 48;
	localparam int COUNT_BITS       = 24;
	localparam int MAX_RESULTS      = 64;

	localparam int REQ_TYPE_W    = 3;
	localparam int PROB_W        = 8;
	localparam int LIT_VALUE_W   = 16;
	localparam int LIT_BITS_W    = 5;
	localparam int BYTE_W        = 8;
	localparam int GAP_W         = 24;
	localparam int BUF_SIZE_W    = 24;
	localparam int STATUS_W      = 2;
	localparam int BYTE_COUNT_W  = 24;

	localparam int FF_RUN_W   = $clog2(MAX_FF_RUN + 1);
	localparam int LIT_CNT_W  = $clog2(MAX_LITERAL_BITS + 1);
	localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);
	localparam int RES_ADDR_W = $clog2(MAX_RESULTS);
	localparam int SHIFT_W    = 5;
	localparam int GAP_SUM_W  = ((COUNT_BITS > GAP_W) ? COUNT_BITS : GAP_W) + 1;

	localparam logic [BYTE_W-1:0]     RANGE_INIT   = 8'd255;
	localparam logic [PROB_W-1:0]     LIT_PROB     = 8'd128;
	localparam logic [SHIFT_W-1:0]    SHIFTS_INIT  = 5'd24;
	localparam logic [SHIFT_W-1:0]    SHIFTS_BYTE  = 5'd8;
	localparam logic [BYTE_W-1:0]     BYTE_FF      = 8'hff;
	localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_INIT = 24'd1048576;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_RESTART = 3'd0,
		REQ_BOOL    = 3'd1,
		REQ_LITERAL = 3'd2,
		REQ_RAW     = 3'd3,
		REQ_GAP     = 3'd4,
		REQ_DRAIN   = 3'd5
	} req_code_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_ROOM = 2'd1,
		STAT_RUN_SAT = 2'd2
	} status_code_t;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0]  req_type;
		logic [PROB_W-1:0]      prob;
		logic                   bit_value;
		logic [LIT_VALUE_W-1:0] lit_value;
		logic [LIT_BITS_W-1:0]  lit_bits;
		logic [BYTE_W-1:0]      raw_byte;
		logic [GAP_W-1:0]       gap_bytes;
	} req_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]       byte_value;
		logic                    byte_valid;
		logic                    last;
		logic [STATUS_W-1:0]     status;
		logic                    overflowed;
		logic [BYTE_COUNT_W-1:0] byte_count;
	} res_item_t;

	typedef struct packed {
		logic load;
		logic restart;
		logic drain;
		logic bool_req;
		logic lit_bool;
		logic carry;
		logic shift;
		logic raw;
		logic gap;
		logic emit;
		logic rd_start;
		logic rd_next;
	} dp_cmd_t;

	typedef struct packed {
		logic range_low;
		logic bottom_msb;
		logic emit_pend;
		logic lit_left;
		logic last;
	} dp_stat_t;

endpackage

// ----- hdl/vbe_req_if.sv -----
// Request channel: valid/ready handshake with the request fields.
interface vbe_req_if import vbe_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [REQ_TYPE_W-1:0]  req_type;
	logic [PROB_W-1:0]      prob;
	logic                   bit_value;
	logic [LIT_VALUE_W-1:0] lit_value;
	logic [LIT_BITS_W-1:0]  lit_bits;
	logic [BYTE_W-1:0]      raw_byte;
	logic [GAP_W-1:0]       gap_bytes;

	modport source (
		output valid, req_type, prob, bit_value, lit_value, lit_bits, raw_byte, gap_bytes,
		input  ready
	);
	modport sink (
		input  valid, req_type, prob, bit_value, lit_value, lit_bits, raw_byte, gap_bytes,
		output ready
	);
endinterface

// ----- hdl/vbe_res_if.sv -----
// Result channel: valid/ready handshake with the result fields.
interface vbe_res_if import vbe_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [BYTE_W-1:0]       byte_value;
	logic                    byte_valid;
	logic                    last;
	logic [STATUS_W-1:0]     status;
	logic                    overflowed;
	logic [BYTE_COUNT_W-1:0] byte_count;

	modport source (
		output valid, byte_value, byte_valid, last, status, overflowed, byte_count,
		input  ready
	);
	modport sink (
		input  valid, byte_value, byte_valid, last, status, overflowed, byte_count,
		output ready
	);
endinterface

// ----- hdl/vbe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ----- hdl/vbe_ctrl.sv -----
// Controller: sequences request execution, normalisation, byte release and result readout.
module vbe_ctrl import vbe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [REQ_TYPE_W-1:0] req_type,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  dp_stat_t              stat,
	output dp_cmd_t               cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LIT,
		S_NORM,
		S_FIN,
		S_READ,
		S_OUT
	} state_t;

	state_t                state_q;
	logic [REQ_TYPE_W-1:0] req_q;
	logic                  in_ready_q;
	logic                  out_valid_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = in_valid && in_ready_q;
			S_EXEC: begin
				case (req_q)
					REQ_RESTART: cmd.restart  = 1'b1;
					REQ_BOOL:    cmd.bool_req = 1'b1;
					REQ_RAW:     cmd.raw      = 1'b1;
					REQ_GAP:     cmd.gap      = 1'b1;
					REQ_DRAIN:   cmd.drain    = 1'b1;
					default:     ;
				endcase
			end
			S_LIT: cmd.lit_bool = stat.lit_left;
			S_NORM: begin
				if (stat.emit_pend) begin
					cmd.emit = 1'b1;
				end else if (stat.range_low) begin
					cmd.carry = stat.bottom_msb;
					cmd.shift = !stat.bottom_msb;
				end
			end
			S_FIN: begin
				cmd.emit     = stat.emit_pend;
				cmd.rd_start = !stat.emit_pend;
			end
			S_OUT: cmd.rd_next = out_ready && !stat.last;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= REQ_RESTART;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						req_q      <= req_type;
						in_ready_q <= 1'b0;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (req_q)
						REQ_BOOL:    state_q <= S_NORM;
						REQ_LITERAL: state_q <= S_LIT;
						default:     state_q <= S_FIN;
					endcase
				end
				S_LIT: begin
					state_q <= stat.lit_left ? S_NORM : S_FIN;
				end
				S_NORM: begin
					if (!stat.emit_pend && !stat.range_low) begin
						state_q <= (req_q == REQ_LITERAL) ? S_LIT : S_FIN;
					end
				end
				S_FIN: begin
					if (!stat.emit_pend) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (stat.last) begin
							in_ready_q <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/vbe_dp.sv -----
// Datapath: coder range and bottom, carry hold and 0xFF run, release buffer and counters.
module vbe_dp import vbe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [BUF_SIZE_W-1:0] cfg_wr_data,
	input  req_item_t             req_item,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	output res_item_t             res_item
);
	logic [BUF_SIZE_W-1:0]  buf_size_q;
	logic [PROB_W-1:0]      prob_q;
	logic                   bit_q;
	logic [LIT_VALUE_W-1:0] lit_q;
	logic [LIT_CNT_W-1:0]   lit_cnt_q;
	logic [BYTE_W-1:0]      raw_q;
	logic [GAP_W-1:0]       gap_q;

	logic [BYTE_W-1:0]      range_q, n_range;
	logic [31:0]            bottom_q, n_bottom;
	logic [SHIFT_W-1:0]     shl_q, n_shl;
	logic [COUNT_BITS-1:0]  count_q, n_count;
	logic [BYTE_W-1:0]      held_q, n_held;
	logic                   held_valid_q, n_held_valid;
	logic [FF_RUN_W-1:0]    run_q, n_run;
	logic                   ovf_q, n_ovf;
	status_code_t           status_q, n_status;

	logic [BYTE_W-1:0]      head_q, n_head;
	logic                   head_pend_q, n_head_pend;
	logic [BYTE_W-1:0]      fill_q, n_fill;
	logic [FF_RUN_W-1:0]    ecnt_q, n_ecnt;

	logic [RES_CNT_W-1:0]   wr_cnt_q;
	logic [RES_ADDR_W-1:0]  rd_idx_q;

	logic [LIT_CNT_W-1:0]   lit_idx;
	logic [LIT_VALUE_W-1:0] lit_sh;
	logic [PROB_W-1:0]      prob_sel;
	logic                   bit_sel;
	logic [15:0]            prod;
	logic [BYTE_W-1:0]      split;
	logic                   gap_fail;
	logic                   arr_en;
	logic [BYTE_W-1:0]      arr_b;
	logic [BYTE_W-1:0]      emit_byte;
	logic                   emit_pend;
	logic                   ram_wr_en;
	logic                   ram_rd_en;
	logic [RES_ADDR_W-1:0]  ram_rd_addr;
	logic [BYTE_W-1:0]      ram_rd_data;
	logic                   no_bytes;
	logic                   last;
	logic [LIT_CNT_W-1:0]   lit_load;

	assign lit_idx  = lit_cnt_q - LIT_CNT_W'(1);
	assign lit_sh   = lit_q >> lit_idx;
	assign prob_sel = cmd.lit_bool ? LIT_PROB : prob_q;
	assign bit_sel  = cmd.lit_bool ? lit_sh[0] : bit_q;
	assign prod     = {8'd0, range_q - 8'd1} * {8'd0, prob_sel};
	assign split    = prod[15:8] + 8'd1;
	assign gap_fail = (GAP_SUM_W'(count_q) + GAP_SUM_W'(gap_q))
		> (ovf_q ? '0 : GAP_SUM_W'(buf_size_q));
	assign lit_load = (32'(req_item.lit_bits) > MAX_LITERAL_BITS)
		? LIT_CNT_W'(MAX_LITERAL_BITS) : LIT_CNT_W'(req_item.lit_bits);

	assign emit_byte = head_pend_q ? head_q : fill_q;
	assign emit_pend = head_pend_q || (ecnt_q != '0);

	always_comb begin
		n_range      = range_q;
		n_bottom     = bottom_q;
		n_shl        = shl_q;
		n_count      = count_q;
		n_held       = held_q;
		n_held_valid = held_valid_q;
		n_run        = run_q;
		n_ovf        = ovf_q;
		n_status     = status_q;
		n_head       = head_q;
		n_head_pend  = head_pend_q;
		n_fill       = fill_q;
		n_ecnt       = ecnt_q;
		arr_en       = cmd.raw;
		arr_b        = raw_q;

		if (cmd.load) begin
			n_status = STAT_OK;
		end
		if (cmd.bool_req || cmd.lit_bool) begin
			if (bit_sel) begin
				n_bottom = bottom_q + 32'(split);
				n_range  = range_q - split;
			end else begin
				n_range = split;
			end
		end
		if (cmd.shift) begin
			n_range = {range_q[6:0], 1'b0};
			if (shl_q <= SHIFT_W'(1)) begin
				arr_en   = 1'b1;
				arr_b    = bottom_q[30:23];
				n_bottom = {8'd0, bottom_q[22:0], 1'b0};
				n_shl    = SHIFTS_BYTE;
			end else begin
				n_bottom = {bottom_q[30:0], 1'b0};
				n_shl    = shl_q - SHIFT_W'(1);
			end
		end
		if (cmd.carry) begin
			n_bottom[31] = 1'b0;
			if (held_valid_q) begin
				if (run_q != '0) begin
					n_head      = held_q + 8'd1;
					n_head_pend = 1'b1;
					n_fill      = 8'h00;
					n_ecnt      = run_q - FF_RUN_W'(1);
					n_held      = 8'h00;
					n_run       = '0;
				end else begin
					n_held = held_q + 8'd1;
				end
			end
		end
		if (cmd.drain || cmd.restart) begin
			if (held_valid_q) begin
				n_head      = held_q;
				n_head_pend = 1'b1;
				n_fill      = BYTE_FF;
				n_ecnt      = run_q;
			end
			n_held_valid = 1'b0;
			n_held       = 8'h00;
			n_run        = '0;
			if (cmd.restart) begin
				n_range  = RANGE_INIT;
				n_bottom = '0;
				n_shl    = SHIFTS_INIT;
				n_count  = '0;
				n_ovf    = 1'b0;
			end
		end
		if (cmd.gap && gap_fail) begin
			n_ovf    = 1'b1;
			n_status = STAT_NO_ROOM;
		end
		if (cmd.emit) begin
			if (head_pend_q) begin
				n_head_pend = 1'b0;
			end else begin
				n_ecnt = ecnt_q - FF_RUN_W'(1);
			end
		end
		if (arr_en) begin
			if (count_q != COUNT_MAX) begin
				n_count = count_q + COUNT_BITS'(1);
			end
			if (!held_valid_q) begin
				n_held       = arr_b;
				n_held_valid = 1'b1;
			end else if (arr_b == BYTE_FF) begin
				if (run_q < FF_RUN_W'(MAX_FF_RUN)) begin
					n_run = run_q + FF_RUN_W'(1);
				end else begin
					n_head      = held_q;
					n_head_pend = 1'b1;
					n_ecnt      = '0;
					n_held      = BYTE_FF;
					n_status    = STAT_RUN_SAT;
				end
			end else begin
				n_head      = held_q;
				n_head_pend = 1'b1;
				n_fill      = BYTE_FF;
				n_ecnt      = run_q;
				n_run       = '0;
				n_held      = arr_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prob_q <= req_item.prob;
			bit_q  <= req_item.bit_value;
			lit_q  <= req_item.lit_value;
			raw_q  <= req_item.raw_byte;
			gap_q  <= req_item.gap_bytes;
		end
		head_q <= n_head;
		fill_q <= n_fill;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q   <= BUF_SIZE_INIT;
			lit_cnt_q    <= '0;
			range_q      <= RANGE_INIT;
			bottom_q     <= '0;
			shl_q        <= SHIFTS_INIT;
			count_q      <= '0;
			held_q       <= 8'h00;
			held_valid_q <= 1'b0;
			run_q        <= '0;
			ovf_q        <= 1'b0;
			status_q     <= STAT_OK;
			head_pend_q  <= 1'b0;
			ecnt_q       <= '0;
			wr_cnt_q     <= '0;
			rd_idx_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				buf_size_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				lit_cnt_q <= lit_load;
			end else if (cmd.lit_bool) begin
				lit_cnt_q <= lit_idx;
			end
			range_q      <= n_range;
			bottom_q     <= n_bottom;
			shl_q        <= n_shl;
			count_q      <= n_count;
			held_q       <= n_held;
			held_valid_q <= n_held_valid;
			run_q        <= n_run;
			ovf_q        <= n_ovf;
			status_q     <= n_status;
			head_pend_q  <= n_head_pend;
			ecnt_q       <= n_ecnt;
			if (cmd.load) begin
				wr_cnt_q <= '0;
			end else if (ram_wr_en) begin
				wr_cnt_q <= wr_cnt_q + RES_CNT_W'(1);
			end
			if (cmd.rd_start) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_next) begin
				rd_idx_q <= rd_idx_q + RES_ADDR_W'(1);
			end
		end
	end

	// drop releases beyond the buffer depth
	assign ram_wr_en   = cmd.emit && (wr_cnt_q < RES_CNT_W'(MAX_RESULTS));
	assign ram_rd_en   = cmd.rd_start || cmd.rd_next;
	assign ram_rd_addr = cmd.rd_start ? '0 : rd_idx_q + RES_ADDR_W'(1);

	vbe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_RESULTS)
	) u_rel_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (wr_cnt_q[RES_ADDR_W-1:0]),
		.wr_data (emit_byte),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign no_bytes = (wr_cnt_q == '0);
	assign last     = no_bytes || ((RES_CNT_W'(rd_idx_q) + RES_CNT_W'(1)) == wr_cnt_q);

	assign stat.range_low  = !range_q[7];
	assign stat.bottom_msb = bottom_q[31];
	assign stat.emit_pend  = emit_pend;
	assign stat.lit_left   = (lit_cnt_q != '0);
	assign stat.last       = last;

	assign res_item.byte_value = no_bytes ? 8'h00 : ram_rd_data;
	assign res_item.byte_valid = !no_bytes;
	assign res_item.last       = last;
	assign res_item.status     = status_q;
	assign res_item.overflowed = ovf_q;
	assign res_item.byte_count = BYTE_COUNT_W'(count_q);
endmodule

// ----- hdl/vp8_bool_encoder_unit.sv -----
// Top level of the VP8 boolean encoder: controller, datapath and port wiring.
//
// Requests enter on req (valid/ready); each transaction is a restart, bool,
// literal, raw byte, gap check or drain. Results leave on res (valid/ready):
// one transaction per released byte (up to 64 per request), or a single one
// with byte_valid low when the request releases nothing; last marks the final
// one, and every result of a request carries the status, overflow mark and
// byte count after it. cfg_wr_en/cfg_wr_data must write the buffer size only
// while the block is idle; the block does not enforce this. One request is
// handled at a time. After acceptance a bool is coded, then renormalised one
// shift at a time (up to 7 shifts), with a separate step per carry; a literal
// codes and renormalises each bit in turn. Each released byte is written into
// the release RAM, then the request finishes and each result is read out of
// the RAM while the receiver is ready. The normaliser, which makes one shift
// or carry per cycle while no byte is pending release, and the result readout
// set the rate. Results appear once the whole request is done.
// A stalled receiver holds the current result; req.ready stays low until the
// last result is taken. Reset puts the coder in its restart state, clears the
// held byte and the overflow mark and loads the default buffer size.
module vp8_bool_encoder_unit import vbe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	vbe_req_if.sink               req,
	vbe_res_if.source             res,
	input  logic                  cfg_wr_en,
	input  logic [BUF_SIZE_W-1:0] cfg_wr_data
);
	req_item_t req_item;
	res_item_t res_item;
	dp_cmd_t   cmd;
	dp_stat_t  stat;

	assign req_item.req_type  = req.req_type;
	assign req_item.prob      = req.prob;
	assign req_item.bit_value = req.bit_value;
	assign req_item.lit_value = req.lit_value;
	assign req_item.lit_bits  = req.lit_bits;
	assign req_item.raw_byte  = req.raw_byte;
	assign req_item.gap_bytes = req.gap_bytes;

	vbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.req_type  (req.req_type),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vbe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_item    (req_item),
		.cmd         (cmd),
		.stat        (stat),
		.res_item    (res_item)
	);

	assign res.byte_value = res_item.byte_value;
	assign res.byte_valid = res_item.byte_valid;
	assign res.last       = res_item.last;
	assign res.status     = res_item.status;
	assign res.overflowed = res_item.overflowed;
	assign res.byte_count = res_item.byte_count;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.valid && req.ready))
		else $error("request taken while a result is offered");

	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && res.last |=> req.ready)
		else $error("request channel not reopened after last result");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.byte_valid |-> res.last)
		else $error("result without a byte is not the last one");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.status == STAT_OK || res.status == STAT_NO_ROOM
			|| res.status == STAT_RUN_SAT))
		else $error("undefined status code");
endmodule

// ----- dv/vp8_bool_encoder_unit_test.sv -----
`timescale 1ns / 100ps
// Testbench for vp8_bool_encoder_unit: directed and random requests checked against a shadow coder.
module vp8_bool_encoder_unit_test;
	import vbe_pkg::*;

	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED_A = 3'd6;
	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED_B = 3'd7;
	localparam int RANDOM_ITEMS     = 200;
	localparam int SETTLE_CYCLES    = 40;
	localparam int LONG_HOLD_CYCLES = 300;

	typedef enum int {FL_NOISE, FL_BOOLS, FL_CARRY, FL_FF} flavour_t;

	class bool_coder_shadow;
		logic [BUF_SIZE_W-1:0] buffer_size;
		int unsigned           coder_range;
		logic [31:0]           coder_bottom;
		int unsigned           shifts_left;
		logic [COUNT_BITS-1:0] bytes_made;
		logic [BYTE_W-1:0]     held;
		bit                    held_ok;
		int unsigned           ff_count;
		bit                    overflow;
		logic [BYTE_W-1:0]     released[$];
		logic [STATUS_W-1:0]   req_status;
		res_item_t             awaited[$];
		int                    faults;

		function new();
			buffer_size  = BUF_SIZE_INIT;
			coder_range  = RANGE_INIT;
			coder_bottom = '0;
			shifts_left  = SHIFTS_INIT;
			bytes_made   = '0;
			held         = '0;
			held_ok      = 1'b0;
			ff_count     = 0;
			overflow     = 1'b0;
			faults       = 0;
		endfunction

		function void emit(logic [BYTE_W-1:0] b);
			if (released.size() < MAX_RESULTS)
				released.push_back(b);
		endfunction

		function void arrive(logic [BYTE_W-1:0] b);
			if (bytes_made != COUNT_MAX)
				bytes_made++;
			if (!held_ok) begin
				held    = b;
				held_ok = 1'b1;
			end else if (b == BYTE_FF) begin
				if (ff_count < MAX_FF_RUN) begin
					ff_count++;
				end else begin
					emit(held);
					held       = BYTE_FF;
					req_status = STAT_RUN_SAT;
				end
			end else begin
				emit(held);
				repeat (ff_count) emit(BYTE_FF);
				ff_count = 0;
				held     = b;
			end
		endfunction

		function void carry();
			if (held_ok) begin
				held = held + 8'd1;
				if (ff_count > 0) begin
					emit(held);
					repeat (ff_count - 1) emit('0);
					held     = '0;
					ff_count = 0;
				end
			end
		endfunction

		function void drain();
			if (held_ok) begin
				emit(held);
				repeat (ff_count) emit(BYTE_FF);
			end
			held_ok  = 1'b0;
			held     = '0;
			ff_count = 0;
		endfunction

		function void code_bool(int unsigned p, logic b);
			int unsigned split;
			split = 1 + (((coder_range - 1) * p) >> 8);
			if (b) begin
				coder_bottom = coder_bottom + split;
				coder_range  = coder_range - split;
			end else begin
				coder_range = split;
			end
			while (coder_range < 128) begin
				if (coder_bottom[31])
					carry();
				coder_range  = coder_range << 1;
				coder_bottom = coder_bottom << 1;
				if (shifts_left <= 1) begin
					arrive(coder_bottom[31:24]);
					coder_bottom = coder_bottom & 32'h00ff_ffff;
					shifts_left  = SHIFTS_BYTE;
				end else begin
					shifts_left--;
				end
			end
		endfunction

		function void note_request(req_item_t it);
			int unsigned nb;
			longint      room;
			int          n;
			res_item_t   r;
			released.delete();
			req_status = STAT_OK;
			case (it.req_type)
				REQ_RESTART: begin
					drain();
					coder_range  = RANGE_INIT;
					coder_bottom = '0;
					shifts_left  = SHIFTS_INIT;
					bytes_made   = '0;
					overflow     = 1'b0;
				end
				REQ_BOOL: code_bool(it.prob, it.bit_value);
				REQ_LITERAL: begin
					nb = it.lit_bits;
					if (nb > MAX_LITERAL_BITS)
						nb = MAX_LITERAL_BITS;
					while (nb > 0) begin
						nb--;
						code_bool(LIT_PROB, it.lit_value[nb]);
					end
				end
				REQ_RAW: arrive(it.raw_byte);
				REQ_GAP: begin
					room = overflow ? 0 : longint'(buffer_size);
					if (longint'(bytes_made) + longint'(it.gap_bytes) > room) begin
						overflow   = 1'b1;
						req_status = STAT_NO_ROOM;
					end
				end
				REQ_DRAIN: drain();
				default: ;
			endcase
			n = released.size() > 0 ? released.size() : 1;
			for (int k = 0; k < n; k++) begin
				r.byte_value = released.size() > 0 ? released[k] : '0;
				r.byte_valid = released.size() > 0;
				r.last       = (k == n - 1);
				r.status     = req_status;
				r.overflowed = overflow;
				r.byte_count = bytes_made;
				awaited.push_back(r);
			end
		endfunction

		function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
			if (exp !== act) begin
				$display("%0t: %s expected %0h, got %0h", $time, name, exp, act);
				faults++;
			end
		endfunction

		function void check_result(res_item_t got);
			res_item_t exp;
			if (awaited.size() == 0) begin
				$display("%0t: result with nothing expected, got byte %0h valid %0b",
					$time, got.byte_value, got.byte_valid);
				faults++;
			end else begin
				exp = awaited.pop_front();
				compare_field("byte_value", exp.byte_value, got.byte_value);
				compare_field("byte_valid", exp.byte_valid, got.byte_valid);
				compare_field("last", exp.last, got.last);
				compare_field("status", exp.status, got.status);
				compare_field("overflowed", exp.overflowed, got.overflowed);
				compare_field("byte_count", exp.byte_count, got.byte_count);
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [BUF_SIZE_W-1:0] cfg_wr_data;
	bit                    calm;
	int                    items_sent;
	int                    results_taken;
	bool_coder_shadow      book = new();

	vbe_req_if req_ch();
	vbe_res_if res_ch();

	vp8_bool_encoder_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.res         (res_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_request(input req_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= it.req_type;
		req_ch.prob      <= it.prob;
		req_ch.bit_value <= it.bit_value;
		req_ch.lit_value <= it.lit_value;
		req_ch.lit_bits  <= it.lit_bits;
		req_ch.raw_byte  <= it.raw_byte;
		req_ch.gap_bytes <= it.gap_bytes;
		do @(posedge clk); while (!req_ch.ready);
		book.note_request(it);
		items_sent++;
	endtask

	task automatic send_fields(input logic [REQ_TYPE_W-1:0] code, input logic [PROB_W-1:0] p,
			input logic b, input logic [LIT_VALUE_W-1:0] lit, input logic [LIT_BITS_W-1:0] nb,
			input logic [BYTE_W-1:0] raw, input logic [GAP_W-1:0] gap);
		req_item_t it;
		it = '{code, p, b, lit, nb, raw, gap};
		send_request(it);
	endtask

	function automatic req_item_t random_request(flavour_t fl);
		req_item_t it;
		int pick;
		it.req_type  = REQ_BOOL;
		it.prob      = PROB_W'($urandom());
		it.bit_value = 1'($urandom());
		it.lit_value = LIT_VALUE_W'($urandom());
		it.lit_bits  = ($urandom_range(0, 3) == 0) ? LIT_BITS_W'($urandom())
			: LIT_BITS_W'($urandom_range(0, 16));
		it.raw_byte  = BYTE_W'($urandom());
		it.gap_bytes = $urandom_range(0, 1) ? GAP_W'($urandom_range(0, 200))
			: GAP_W'($urandom());
		case (fl)
			FL_BOOLS: it.req_type = ($urandom_range(0, 9) < 7) ? REQ_BOOL : REQ_LITERAL;
			FL_CARRY: begin
				it.bit_value = 1'b1;
				it.prob      = PROB_W'($urandom_range(192, 255));
			end
			FL_FF: begin
				it.req_type = REQ_RAW;
				it.raw_byte = BYTE_FF;
			end
			default: begin
				pick = $urandom_range(0, 19);
				if (pick < 6)
					it.req_type = REQ_BOOL;
				else if (pick < 9)
					it.req_type = REQ_LITERAL;
				else if (pick < 12)
					it.req_type = REQ_RAW;
				else if (pick < 15)
					it.req_type = REQ_GAP;
				else if (pick < 17)
					it.req_type = REQ_DRAIN;
				else if (pick < 18)
					it.req_type = REQ_RESTART;
				else if (pick < 19)
					it.req_type = REQ_UNUSED_A;
				else
					it.req_type = REQ_UNUSED_B;
			end
		endcase
		return it;
	endfunction

	task automatic wait_for_quiet();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (book.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_buffer_size(input logic [BUF_SIZE_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		book.buffer_size = v;
	endtask

	// result side: random stalls, plus two long hold-offs to back up the request side
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			book.check_result('{res_ch.byte_value, res_ch.byte_valid, res_ch.last,
				res_ch.status, res_ch.overflowed, res_ch.byte_count});
			results_taken++;
			if (results_taken == 60 || results_taken == 200) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	initial begin
		flavour_t fl;
		int       kind;
		int       len;
		int       phase_end;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_RESTART;
		req_ch.prob      <= '0;
		req_ch.bit_value <= 1'b0;
		req_ch.lit_value <= '0;
		req_ch.lit_bits  <= '0;
		req_ch.raw_byte  <= '0;
		req_ch.gap_bytes <= '0;
		cfg_wr_en        <= 1'b0;
		cfg_wr_data      <= '0;
		arst_n           <= 1'b0;
		calm          = 1'b0;
		items_sent    = 0;
		results_taken = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_fields(REQ_BOOL, 8'd0, 1'b0, '0, '0, '0, '0);
		send_fields(REQ_BOOL, 8'd255, 1'b1, '0, '0, '0, '0);
		send_fields(REQ_BOOL, 8'd0, 1'b1, '0, '0, '0, '0);
		send_fields(REQ_BOOL, 8'd255, 1'b0, '0, '0, '0, '0);
		send_fields(REQ_LITERAL, '0, 1'b0, 16'h0000, 5'd0, '0, '0);
		send_fields(REQ_LITERAL, '0, 1'b0, 16'hffff, 5'd16, '0, '0);
		send_fields(REQ_LITERAL, '0, 1'b0, 16'ha5c3, 5'd31, '0, '0);
		send_fields(REQ_LITERAL, '0, 1'b0, 16'h0000, 5'd16, '0, '0);
		send_fields(REQ_LITERAL, '0, 1'b0, 16'h8001, 5'd17, '0, '0);
		send_fields(REQ_RAW, '0, 1'b0, '0, '0, 8'h00, '0);
		send_fields(REQ_RAW, '0, 1'b0, '0, '0, BYTE_FF, '0);
		send_fields(REQ_RAW, '0, 1'b0, '0, '0, BYTE_FF, '0);
		send_fields(REQ_GAP, '0, 1'b0, '0, '0, '0, 24'd0);
		send_fields(REQ_GAP, '0, 1'b0, '0, '0, '0, 24'hffffff);
		send_fields(REQ_GAP, '0, 1'b0, '0, '0, '0, 24'd0);
		send_fields(REQ_DRAIN, '0, 1'b0, '0, '0, '0, '0);
		send_fields(REQ_DRAIN, '0, 1'b0, '0, '0, '0, '0);
		send_fields(REQ_UNUSED_A, 8'hff, 1'b1, 16'hffff, 5'd31, 8'hff, 24'hffffff);
		send_fields(REQ_UNUSED_B, 8'hff, 1'b1, 16'hffff, 5'd31, 8'hff, 24'hffffff);
		send_fields(REQ_RESTART, '0, 1'b0, '0, '0, '0, '0);
		send_fields(REQ_GAP, '0, 1'b0, '0, '0, '0, 24'd0);
		send_fields(REQ_RAW, '0, 1'b0, '0, '0, BYTE_FF, '0);
		send_fields(REQ_LITERAL, '0, 1'b0, 16'hffff, 5'd16, '0, '0);
		send_fields(REQ_RESTART, '0, 1'b0, '0, '0, '0, '0);

		for (int ph = 0; ph < 4; ph++) begin
			wait_for_quiet();
			case (ph)
				0: write_buffer_size(24'd1);
				1: write_buffer_size({BUF_SIZE_W{1'b1}});
				2: write_buffer_size(BUF_SIZE_W'($urandom_range(2, 300)));
				default: write_buffer_size(BUF_SIZE_W'($urandom_range(1, 24'hffffff)));
			endcase
			phase_end = items_sent + RANDOM_ITEMS / 4;
			if (ph == 0) begin
				send_request(random_request(FL_BOOLS));
				repeat ($urandom_range(50, 54)) send_request(random_request(FL_FF));
				repeat ($urandom_range(4, 10)) send_request(random_request(FL_CARRY));
			end
			while (items_sent < phase_end) begin
				calm = ($urandom_range(0, 3) == 0);
				kind = $urandom_range(0, 9);
				fl = (kind < 3) ? FL_NOISE : (kind < 6) ? FL_BOOLS : (kind < 8) ? FL_CARRY : FL_FF;
				if (fl == FL_FF)
					len = ($urandom_range(0, 5) == 0) ? $urandom_range(49, 56) : $urandom_range(1, 8);
				else
					len = $urandom_range(4, 20);
				repeat (len) send_request(random_request(fl));
				if (fl == FL_FF)
					repeat ($urandom_range(2, 8)) send_request(random_request(FL_CARRY));
				if ($urandom_range(0, 7) == 0)
					wait_for_quiet();
			end
		end

		wait_for_quiet();
		if (book.faults == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/vbe_pkg.sv
hdl/vbe_req_if.sv
hdl/vbe_res_if.sv
hdl/vbe_ram.sv
hdl/vbe_ctrl.sv
hdl/vbe_dp.sv
hdl/vp8_bool_encoder_unit.sv
dv/vp8_bool_encoder_unit_test.sv
